// ===== hdl/tabsq_pkg.sv =====
package tabsq_pkg;

    // Vector buffer geometry
    localparam int VECTOR_DEPTH = 64;
    localparam int IDX_W        = $clog2(VECTOR_DEPTH);
    localparam int CNT_W        = $clog2(VECTOR_DEPTH + 1);
    localparam int BANK_COUNT   = 2;
    localparam int RAM_DEPTH    = BANK_COUNT * VECTOR_DEPTH;
    localparam int RAM_ADDR_W   = IDX_W + 1;

    // Payload widths
    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = 16;
    localparam int MAG10_W  = MAG_W + 4;
    localparam int CODE_W   = 2;
    localparam int DEQ_W    = 17;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_QUANT_MODE = 1'b0;

    localparam logic QMODE_TERNARY = 1'b0;
    localparam logic QMODE_BINARY  = 1'b1;

    localparam logic signed [CODE_W-1:0] CODE_ZERO = 2'sd0;
    localparam logic signed [CODE_W-1:0] CODE_POS  = 2'sd1;
    localparam logic signed [CODE_W-1:0] CODE_NEG  = -2'sd1;

    // One finished vector handed from the loader to the emitter
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [MAG_W-1:0] max_mag;
        logic             overflow;
    } desc_t;

    typedef struct packed {
        logic signed [CODE_W-1:0] code;
        logic signed [DEQ_W-1:0]  dequantized;
        logic                     dropped;
        logic                     last_out;
    } result_t;

endpackage

// ===== hdl/ternary_absmax_quantizer.sv =====
// Channel   Direction  Handshake                  Payload
// input     in         push / full                sample, is_last
// result    out        pop / empty                code, dequantized, dropped, last_out
// config    in/out     psel, penable, pwrite,     paddr, pwdata, prdata (quant_mode)
//                      pready (always high)
//
// One input transaction is taken per cycle while full is low; loading an
// element costs one sample RAM write port access. Emission reads the sample
// RAM once per element: at most one result every cycle with pop held high.
// Two RAM banks let the next vector load while the previous one drains; full
// is high while both banks hold vectors whose read-out has not finished.
// Reset clears all control state; sample RAM contents are left undefined.
module ternary_absmax_quantizer (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // input queue side
    input  logic                                    push,
    output logic                                    full,
    input  logic signed [tabsq_pkg::SAMPLE_W-1:0]   sample,
    input  logic                                    is_last,
    // result queue side
    input  logic                                    pop,
    output logic                                    empty,
    output logic signed [tabsq_pkg::CODE_W-1:0]     code,
    output logic signed [tabsq_pkg::DEQ_W-1:0]      dequantized,
    output logic                                    dropped,
    output logic                                    last_out,
    // configuration
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [tabsq_pkg::PADDR_W-1:0]           paddr,
    input  logic [tabsq_pkg::PDATA_W-1:0]           pwdata,
    output logic [tabsq_pkg::PDATA_W-1:0]           prdata,
    output logic                                    pready
);
    import tabsq_pkg::*;

    logic                  quant_mode_reg, quant_mode_next;
    logic                  in_accept;
    logic                  ram_wr_en;
    logic [RAM_ADDR_W-1:0] ram_wr_addr;
    logic                  ram_rd_en;
    logic [RAM_ADDR_W-1:0] ram_rd_addr;
    logic [SAMPLE_W-1:0]   ram_rd_data;
    logic                  desc_push;
    logic                  desc_pop;
    logic                  desc_valid;
    desc_t                 desc_in;
    desc_t                 desc_head;
    result_t               result;

    // Configuration: a single mode bit at word 0
    assign pready = 1'b1;

    always_comb
    begin
        quant_mode_next = quant_mode_reg;
        if (psel && penable && pwrite && pready && (paddr[2] == REG_QUANT_MODE))
        begin
            quant_mode_next = pwdata[0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_QUANT_MODE)
        begin
            prdata = {{(PDATA_W-1){1'b0}}, quant_mode_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quant_mode_reg <= QMODE_TERNARY;
        end
        else
        begin
            quant_mode_reg <= quant_mode_next;
        end
    end

    // Accept while a free bank remains
    assign in_accept = push && !full;

    tabsq_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_accept   (in_accept),
        .sample      (sample),
        .is_last     (is_last),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .desc_push   (desc_push),
        .desc_out    (desc_in)
    );

    tabsq_sample_ram u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (sample),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Hold one descriptor per loaded bank between the two sides
    tabsq_desc_fifo u_desc_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (desc_push),
        .push_data (desc_in),
        .pop       (desc_pop),
        .head      (desc_head),
        .not_empty (desc_valid),
        .is_full   (full)
    );

    tabsq_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .quant_mode  (quant_mode_reg),
        .desc_valid  (desc_valid),
        .desc        (desc_head),
        .desc_pop    (desc_pop),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .pop         (pop),
        .empty       (empty),
        .result      (result)
    );

    assign code        = result.code;
    assign dequantized = result.dequantized;
    assign dropped     = result.dropped;
    assign last_out    = result.last_out;

endmodule

// ===== hdl/tabsq_sample_ram.sv =====
module tabsq_sample_ram (
    input  logic                                 clk,
    input  logic                                 wr_en,
    input  logic [tabsq_pkg::RAM_ADDR_W-1:0]     wr_addr,
    input  logic [tabsq_pkg::SAMPLE_W-1:0]       wr_data,
    input  logic                                 rd_en,
    input  logic [tabsq_pkg::RAM_ADDR_W-1:0]     rd_addr,
    output logic [tabsq_pkg::SAMPLE_W-1:0]       rd_data
);
    import tabsq_pkg::*;

    logic [SAMPLE_W-1:0] mem [RAM_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/tabsq_front.sv =====
module tabsq_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_accept,
    input  logic [tabsq_pkg::SAMPLE_W-1:0]       sample,
    input  logic                                 is_last,
    output logic                                 ram_wr_en,
    output logic [tabsq_pkg::RAM_ADDR_W-1:0]     ram_wr_addr,
    output logic                                 desc_push,
    output tabsq_pkg::desc_t                     desc_out
);
    import tabsq_pkg::*;

    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [MAG_W-1:0] max_reg, max_next;
    logic             ovf_reg, ovf_next;
    logic             bank_reg, bank_next;
    logic [MAG_W-1:0] mag;
    logic             has_room;

    assign mag      = sample[SAMPLE_W-1] ? MAG_W'(~sample + 1'b1) : sample;
    assign has_room = fill_reg < CNT_W'(VECTOR_DEPTH);

    assign ram_wr_en   = in_accept && has_room;
    assign ram_wr_addr = {bank_reg, fill_reg[IDX_W-1:0]};

    always_comb
    begin
        fill_next = fill_reg;
        max_next  = max_reg;
        ovf_next  = ovf_reg;
        bank_next = bank_reg;
        desc_push = 1'b0;
        // Fold the current item in before closing the vector
        if (in_accept)
        begin
            if (has_room)
            begin
                fill_next = fill_reg + 1'b1;
                if (mag > max_reg)
                begin
                    max_next = mag;
                end
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        desc_out.count    = fill_next;
        desc_out.max_mag  = max_next;
        desc_out.overflow = ovf_next;
        // Hand the vector over and switch to the other bank
        if (in_accept && is_last)
        begin
            desc_push = 1'b1;
            fill_next = '0;
            max_next  = '0;
            ovf_next  = 1'b0;
            bank_next = ~bank_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            max_reg  <= '0;
            ovf_reg  <= 1'b0;
            bank_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            max_reg  <= max_next;
            ovf_reg  <= ovf_next;
            bank_reg <= bank_next;
        end
    end

endmodule

// ===== hdl/tabsq_desc_fifo.sv =====
module tabsq_desc_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  tabsq_pkg::desc_t push_data,
    input  logic             pop,
    output tabsq_pkg::desc_t head,
    output logic             not_empty,
    output logic             is_full
);
    import tabsq_pkg::*;

    desc_t      slot_reg [BANK_COUNT];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign head      = slot_reg[rd_ptr_reg];
    assign not_empty = cnt_reg != 2'd0;
    assign is_full   = cnt_reg == 2'(BANK_COUNT);

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== hdl/tabsq_back.sv =====
module tabsq_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 quant_mode,
    input  logic                                 desc_valid,
    input  tabsq_pkg::desc_t                     desc,
    output logic                                 desc_pop,
    output logic                                 ram_rd_en,
    output logic [tabsq_pkg::RAM_ADDR_W-1:0]     ram_rd_addr,
    input  logic [tabsq_pkg::SAMPLE_W-1:0]       ram_rd_data,
    input  logic                                 pop,
    output logic                                 empty,
    output tabsq_pkg::result_t                   result
);
    import tabsq_pkg::*;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             bank_reg, bank_next;
    logic             issue_last;
    logic             s1_valid_reg;
    logic [MAG_W-1:0] s1_max_reg;
    logic             s1_ovf_reg;
    logic             s1_last_reg;

    result_t          q_reg [2];
    logic             q_wr_reg, q_rd_reg;
    logic [1:0]       q_cnt_reg, q_cnt_next;
    logic             q_pop;
    logic [2:0]       room_used;

    logic [MAG_W-1:0]         mag;
    logic [MAG10_W-1:0]       mag10;
    logic signed [CODE_W-1:0] code;
    result_t                  computed;

    // Issue a read only if the result queue can take it after the pending one
    assign q_pop      = pop && (q_cnt_reg != 2'd0);
    assign room_used  = {1'b0, q_cnt_reg} + {2'b0, s1_valid_reg} - {2'b0, q_pop};
    assign ram_rd_en  = desc_valid && (room_used < 3'd2);
    assign ram_rd_addr = {bank_reg, idx_reg};
    assign issue_last = (CNT_W'(idx_reg) + 1'b1) == desc.count;
    assign desc_pop   = ram_rd_en && issue_last;

    always_comb
    begin
        idx_next  = idx_reg;
        bank_next = bank_reg;
        if (ram_rd_en)
        begin
            if (issue_last)
            begin
                idx_next  = '0;
                bank_next = ~bank_reg;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_rd_en)
        begin
            s1_max_reg  <= desc.max_mag;
            s1_ovf_reg  <= desc.overflow;
            s1_last_reg <= issue_last;
        end
    end

    // Classify the sample against the dead zone (by sign alone in binary mode)
    assign mag   = ram_rd_data[SAMPLE_W-1] ? MAG_W'(~ram_rd_data + 1'b1) : ram_rd_data;
    assign mag10 = MAG10_W'({mag, 3'b000}) + MAG10_W'({mag, 1'b0});

    always_comb
    begin
        if (quant_mode == QMODE_BINARY)
        begin
            code = ram_rd_data[SAMPLE_W-1] ? CODE_NEG : CODE_POS;
        end
        else if ((mag == '0) || (mag10 < MAG10_W'(s1_max_reg)))
        begin
            code = CODE_ZERO;
        end
        else
        begin
            code = ram_rd_data[SAMPLE_W-1] ? CODE_NEG : CODE_POS;
        end
        computed.code = code;
        case (code)
            CODE_POS: computed.dequantized = {1'b0, s1_max_reg};
            CODE_NEG: computed.dequantized = DEQ_W'(~{1'b0, s1_max_reg} + 1'b1);
            default:  computed.dequantized = '0;
        endcase
        computed.dropped  = s1_ovf_reg;
        computed.last_out = s1_last_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            q_reg[q_wr_reg] <= computed;
        end
    end

    assign q_cnt_next = q_cnt_reg + {1'b0, s1_valid_reg} - {1'b0, q_pop};
    assign empty      = q_cnt_reg == 2'd0;
    assign result     = q_reg[q_rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            bank_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
            q_wr_reg     <= 1'b0;
            q_rd_reg     <= 1'b0;
            q_cnt_reg    <= 2'd0;
        end
        else
        begin
            idx_reg      <= idx_next;
            bank_reg     <= bank_next;
            s1_valid_reg <= ram_rd_en;
            q_wr_reg     <= s1_valid_reg ? ~q_wr_reg : q_wr_reg;
            q_rd_reg     <= q_pop ? ~q_rd_reg : q_rd_reg;
            q_cnt_reg    <= q_cnt_next;
        end
    end

endmodule
